### rtl/ndft_pkg.sv
`default_nettype none
package ndft_pkg;
    localparam int MAX_POINTS_DEF = 64;
    localparam int SAMPLE_W = 16;
    localparam int L_W = 3;
    localparam int ACC_W = 40;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MAC,
        BK_FLUSH,
        BK_EMIT
    } bk_state_t;

    // Queue entry between front and back: one complete block ready to transform
    typedef struct packed {
        logic [L_W-1:0] log2_n;
        logic           bank;
    } blk_desc_t;

    function automatic logic signed [16:0] rom_cos(input logic [5:0] addr);
        logic [4:0] q;
        logic signed [16:0] v;
        begin
            q = 5'd0;
            if (addr <= 6'd16)      q = addr[4:0];
            else if (addr <= 6'd32) q = 5'(6'd32 - addr);
            else if (addr <= 6'd48) q = 5'(addr - 6'd32);
            else                    q = 5'(7'd64 - {1'b0, addr});
            case (q)
                5'd0:  v = 17'sd32767;
                5'd1:  v = 17'sd32610;
                5'd2:  v = 17'sd32138;
                5'd3:  v = 17'sd31357;
                5'd4:  v = 17'sd30274;
                5'd5:  v = 17'sd28899;
                5'd6:  v = 17'sd27246;
                5'd7:  v = 17'sd25330;
                5'd8:  v = 17'sd23170;
                5'd9:  v = 17'sd20788;
                5'd10: v = 17'sd18205;
                5'd11: v = 17'sd15447;
                5'd12: v = 17'sd12540;
                5'd13: v = 17'sd9512;
                5'd14: v = 17'sd6393;
                5'd15: v = 17'sd3212;
                default: v = 17'sd0;
            endcase
            if (addr > 6'd16 && addr <= 6'd48) rom_cos = -v;
            else rom_cos = v;
        end
    endfunction
endpackage
`default_nettype wire

### rtl/ndft_front.sv
`default_nettype none
module ndft_front #(
    parameter int MAX_POINTS = ndft_pkg::MAX_POINTS_DEF,
    parameter int AW = $clog2(MAX_POINTS)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output      logic                          full,
    input  wire logic [15:0]                   sample,
    input  wire logic [2:0]                    log2_length,
    input  wire logic                          cfg_wr,
    // queue to back end
    output      logic                          q_valid,
    output      ndft_pkg::blk_desc_t           q_desc,
    input  wire logic                          q_take,
    input  wire logic                          bk_busy,
    input  wire logic                          rd_bank,
    input  wire logic [AW-1:0]                 rd_addr,
    output      logic signed [15:0]            rd_data
);
    import ndft_pkg::*;

    // largest block length that fits MAX_POINTS
    localparam int LMAX = $clog2(MAX_POINTS + 1) - 1;

    logic [15:0]        mem [2**(AW+1)];
    logic [AW:0]        load_count_reg, load_count_next;
    logic               wr_bank_reg;
    logic               q_valid_reg;
    blk_desc_t          q_desc_reg;
    logic [L_W-1:0]     eff_l;
    logic [AW:0]        n_pts;
    logic               acc_ok, ends_blk;

    always_comb
    begin
        eff_l = log2_length;
        if (eff_l < 3'd1) eff_l = 3'd1;
        if (eff_l > 3'd6) eff_l = 3'd6;
        if (eff_l > L_W'(LMAX)) eff_l = L_W'(LMAX);
    end

    assign n_pts = (AW+1)'(1) << eff_l;
    // the bank being filled may not be the one still queued or under transform
    assign full = q_valid_reg && (wr_bank_reg == q_desc_reg.bank || bk_busy);
    assign acc_ok = push && !full;
    assign ends_blk = (load_count_reg + 1'b1) >= n_pts;
    assign q_valid = q_valid_reg;
    assign q_desc = q_desc_reg;

    always_comb
    begin
        load_count_next = load_count_reg;
        if (cfg_wr) load_count_next = '0;
        else if (acc_ok) load_count_next = ends_blk ? '0 : load_count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
            wr_bank_reg <= 1'b0;
            q_valid_reg <= 1'b0;
            q_desc_reg <= '0;
        end
        else
        begin
            load_count_reg <= load_count_next;
            if (acc_ok && ends_blk && !cfg_wr)
            begin
                q_valid_reg <= 1'b1;
                q_desc_reg.bank <= wr_bank_reg;
                q_desc_reg.log2_n <= eff_l;
                wr_bank_reg <= !wr_bank_reg;
            end
            else if (q_take) q_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_ok)
            mem[{wr_bank_reg, load_count_reg[AW-1:0]}] <= sample;
        rd_data <= mem[{rd_bank, rd_addr}];
    end
endmodule
`default_nettype wire

### rtl/ndft_back.sv
`default_nettype none
module ndft_back #(
    parameter int MAX_POINTS = ndft_pkg::MAX_POINTS_DEF,
    parameter int AW = $clog2(MAX_POINTS)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire ndft_pkg::blk_desc_t           q_desc,
    output      logic                          q_take,
    output      logic                          bk_busy,
    output      logic                          rd_bank,
    output      logic [AW-1:0]                 rd_addr,
    input  wire logic signed [15:0]            rd_data,
    output      logic                          empty,
    input  wire logic                          pop,
    output      logic [5:0]                    bin_index,
    output      logic signed [15:0]            real_part,
    output      logic signed [15:0]            imag_part,
    output      logic                          last_bin
);
    import ndft_pkg::*;

    bk_state_t state_reg, state_next;
    blk_desc_t desc_reg;
    logic [AW:0]  k_reg, n_reg;
    logic         mac_d1_reg, mac_d2_reg;
    logic signed [16:0] cr_reg, ci_reg;
    logic signed [32:0] pr_reg, pi_reg;
    logic signed [ACC_W-1:0] ar_reg, ai_reg;
    logic         ov_reg;
    logic [5:0]   ob_reg;
    logic signed [15:0] ore_reg, oim_reg;
    logic         olast_reg;
    logic [AW:0]  n_pts;
    logic [AW-1:0] kn;
    logic [5:0]   addr;
    logic         step_mac, last_n, k_last;
    logic         q_take_c;

    assign n_pts  = (AW+1)'(1) << desc_reg.log2_n;
    assign kn     = AW'(k_reg * n_reg) & AW'(n_pts - 1'b1);
    assign addr   = 6'(6'({{(6-AW){1'b0}}, kn} << (3'd6 - desc_reg.log2_n)));
    assign last_n = (n_reg + 1'b1) == n_pts;
    assign k_last = (k_reg + 1'b1) == n_pts;
    assign rd_bank = desc_reg.bank;
    assign rd_addr = n_reg[AW-1:0];

    function automatic logic signed [15:0] scale_sat(input logic signed [ACC_W-1:0] a,
                                                     input logic [L_W-1:0] l);
        logic [4:0] sh;
        logic signed [ACC_W:0] r;
        begin
            sh = 5'd15 + 5'(l);
            r = ($signed({a[ACC_W-1], a}) + ((ACC_W+1)'(1) << (sh - 5'd1))) >>> sh;
            if (r > 32767) scale_sat = 16'sh7FFF;
            else if (r < -32768) scale_sat = 16'sh8000;
            else scale_sat = r[15:0];
        end
    endfunction

    always_comb
    begin
        state_next = state_reg;
        step_mac = 1'b0;
        q_take_c = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_take_c = 1'b1;
                    state_next = BK_MAC;
                end
            end
            BK_MAC:
            begin
                step_mac = 1'b1;
                if (last_n) state_next = BK_FLUSH;
            end
            BK_FLUSH:
            begin
                if (!mac_d1_reg && !mac_d2_reg) state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                // hold until the output stage is free
                if (!ov_reg || pop)
                    state_next = (k_last) ? BK_IDLE : BK_MAC;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    assign q_take = q_take_c;
    assign bk_busy = state_reg != BK_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            mac_d1_reg <= 1'b0;
            mac_d2_reg <= 1'b0;
            ov_reg <= 1'b0;
            k_reg <= '0;
            n_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mac_d1_reg <= step_mac;
            mac_d2_reg <= mac_d1_reg;
            if (q_take_c)
            begin
                k_reg <= '0;
                n_reg <= '0;
            end
            if (step_mac) n_reg <= last_n ? '0 : n_reg + 1'b1;
            if (state_reg == BK_EMIT && (!ov_reg || pop))
            begin
                ov_reg <= 1'b1;
                k_reg <= k_reg + 1'b1;
            end
            else if (pop && ov_reg) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_take_c) desc_reg <= q_desc;
        // stage 1: memory read and twiddle lookup
        cr_reg <= rom_cos(addr);
        ci_reg <= rom_cos(addr + 6'd48);
        // stage 2: products
        pr_reg <= rd_data * cr_reg;
        pi_reg <= rd_data * ci_reg;
        if (state_reg == BK_IDLE || (state_reg == BK_EMIT && (!ov_reg || pop)))
        begin
            ar_reg <= '0;
            ai_reg <= '0;
        end
        else if (mac_d2_reg)
        begin
            ar_reg <= ar_reg + ACC_W'(pr_reg);
            ai_reg <= ai_reg - ACC_W'(pi_reg);
        end
        if (state_reg == BK_EMIT && (!ov_reg || pop))
        begin
            ob_reg <= 6'(k_reg);
            ore_reg <= scale_sat(ar_reg, desc_reg.log2_n);
            oim_reg <= scale_sat(ai_reg, desc_reg.log2_n);
            olast_reg <= k_last;
        end
    end

    assign empty = !ov_reg;
    assign bin_index = ob_reg;
    assign real_part = ore_reg;
    assign imag_part = oim_reg;
    assign last_bin = olast_reg;

    // twiddles register alongside the memory read, so both reach the multiplier together
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> state_reg == BK_IDLE) else $error("take outside idle");
    a_mac_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        mac_d2_reg |-> $past(mac_d1_reg)) else $error("mac pipe broken");
    a_emit_flushed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_EMIT |-> !mac_d2_reg) else $error("emit before flush");
endmodule
`default_nettype wire

### rtl/normalized_dft_block_unit.sv
`default_nettype none
// Direct normalised DFT over blocks of 2^log2_length signed Q1.15 samples.
// Samples transfer in through push/full into a double-banked sample memory;
// once a block is complete it is queued for the transform engine and the
// next block may be loaded meanwhile. The engine runs one complex
// multiply-accumulate per cycle on its single shared MAC, except while it
// waits in the flush or holds a bin back for a full output stage. Bins
// leave in ascending order through empty/pop, last_bin marking bin N-1.
// Write log2_length only while idle; the write restarts block loading.
module normalized_dft_block_unit #(
    parameter int MAX_POINTS = ndft_pkg::MAX_POINTS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [0:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output      logic [31:0]   prdata,
    output      logic          pready,
    input  wire logic          push,
    output      logic          full,
    input  wire logic [15:0]   sample,
    output      logic          empty,
    input  wire logic          pop,
    output      logic [5:0]    bin_index,
    output      logic [15:0]   real_part,
    output      logic [15:0]   imag_part,
    output      logic          last_bin
);
    import ndft_pkg::*;
    localparam int AW = $clog2(MAX_POINTS);

    logic [2:0]        log2_length_reg;
    logic              cfg_wr;
    logic              q_valid, q_take, bk_busy, rd_bank;
    blk_desc_t         q_desc;
    logic [AW-1:0]     rd_addr;
    logic signed [15:0] rd_data;

    assign pready = 1'b1;
    // register 0 lives at byte address 0; paddr is a word select
    assign cfg_wr = psel && penable && pwrite && (paddr == 1'b0);
    assign prdata = {29'd0, log2_length_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) log2_length_reg <= 3'd6;
        else if (cfg_wr) log2_length_reg <= pwdata[2:0];
    end

    ndft_front #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .sample(sample),
        .log2_length(log2_length_reg), .cfg_wr(cfg_wr),
        .q_valid(q_valid), .q_desc(q_desc), .q_take(q_take), .bk_busy(bk_busy),
        .rd_bank(rd_bank), .rd_addr(rd_addr), .rd_data(rd_data)
    );

    ndft_back #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_desc(q_desc),
        .q_take(q_take), .bk_busy(bk_busy), .rd_bank(rd_bank), .rd_addr(rd_addr),
        .rd_data(rd_data), .empty(empty), .pop(pop), .bin_index(bin_index),
        .real_part(real_part), .imag_part(imag_part), .last_bin(last_bin)
    );
endmodule
`default_nettype wire

### bench/normalized_dft_block_unit_test.sv
`timescale 1ns / 100ps

module normalized_dft_block_unit_test;

    // One frequency bin as the block presents it
    typedef struct {
        logic [5:0]  k;
        logic [15:0] re;
        logic [15:0] im;
        logic        last;
    } bin_t;

    // Scoreboard: mirrors the block's sample store and load counter, works out
    // every bin when a block completes and checks the bins as they transfer out.
    class bin_scoreboard;
        logic signed [15:0] store [64];
        int                 fill;
        int                 log2_eff;
        bin_t               bins_due [$];
        int                 mismatches;

        function new();
            fill = 0;
            log2_eff = 6;
            mismatches = 0;
        endfunction

        function int cos_q15(int a);
            int quarter [17] = '{32767, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
                                 23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
            a = a & 63;
            if (a <= 16) return quarter[a];
            if (a <= 32) return -quarter[32 - a];
            if (a <= 48) return -quarter[a - 32];
            return quarter[64 - a];
        endfunction

        // Shift with round half up, then clamp to Q1.15
        function logic [15:0] round_sat(longint acc, int sh);
            longint v;
            v = (acc + (64'sd1 <<< (sh - 1))) >>> sh;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[15:0];
        endfunction

        function void set_length(logic [2:0] code);
            int l;
            l = code;
            if (l < 1) l = 1;
            if (l > 6) l = 6;
            log2_eff = l;
            fill = 0;
        endfunction

        function void note_sample(logic [15:0] s);
            int     npts;
            longint acc_re;
            longint acc_im;
            int     addr;
            bin_t   b;
            npts = 1 << log2_eff;
            store[fill] = s;
            fill++;
            if (fill < npts) return;
            fill = 0;
            for (int k = 0; k < npts; k++)
            begin
                acc_re = 0;
                acc_im = 0;
                for (int n = 0; n < npts; n++)
                begin
                    addr = (((k * n) & (npts - 1)) << (6 - log2_eff)) & 63;
                    acc_re += longint'(store[n]) * cos_q15(addr);
                    acc_im -= longint'(store[n]) * cos_q15(addr + 48);
                end
                b.k = k[5:0];
                b.re = round_sat(acc_re, 15 + log2_eff);
                b.im = round_sat(acc_im, 15 + log2_eff);
                b.last = (k == npts - 1);
                bins_due.push_back(b);
            end
        endfunction

        function void check_bin(bin_t got);
            bin_t want;
            if (bins_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected bin k=%0d re=%h im=%h last=%b",
                             got.k, got.re, got.im, got.last);
                return;
            end
            want = bins_due.pop_front();
            if (got.k !== want.k || got.re !== want.re || got.im !== want.im
                || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("bin mismatch: want k=%0d re=%h im=%h last=%b, got k=%0d re=%h im=%h last=%b",
                             want.k, want.re, want.im, want.last,
                             got.k, got.re, got.im, got.last);
            end
        endfunction

        function int pending();
            return bins_due.size();
        endfunction
    endclass

    localparam int STALL_LIMIT = 60000;
    localparam int SETTLE_CYCLES = 5000;   // one 64-point transform with margin
    localparam int HOLD_CYCLES = 2500;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [0:0]  paddr = 1'b0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        push = 1'b0;
    logic        full;
    logic [15:0] sample = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [5:0]  bin_index;
    logic [15:0] real_part;
    logic [15:0] imag_part;
    logic        last_bin;

    bin_scoreboard sb;
    int  stall_count = 0;
    bit  quiet = 1'b0;        // suppress idling on both sides
    bit  hold_request = 1'b0; // ask the receiver for a long hold-off
    int  leftover_errors = 0;

    normalized_dft_block_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .empty     (empty),
        .pop       (pop),
        .bin_index (bin_index),
        .real_part (real_part),
        .imag_part (imag_part),
        .last_bin  (last_bin)
    );

    always #5 clk = ~clk;

    function int idle_gap();
        if (quiet || $urandom_range(0, 99) >= 14) return 0;
        return $urandom_range(1, 6);
    endfunction

    // Watchdog: end the run if nothing transfers for too long
    always @(posedge clk)
    begin
        stall_count++;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: decide pop at the edge, sample outputs at the falling edge,
    // the transfer itself happens at the following rising edge.
    initial
    begin
        bin_t got;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            pop <= (idle_gap() == 0);
            @(negedge clk);
            if (pop && !empty)
            begin
                got.k = bin_index;
                got.re = real_part;
                got.im = imag_part;
                got.last = last_bin;
                sb.check_bin(got);
                stall_count = 0;
            end
        end
    end

    // Offer one sample; return once it has transferred, at the accepting edge
    task automatic send_sample(logic [15:0] v);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        sample <= v;
        forever
        begin
            @(negedge clk);
            if (!full) break;
            @(posedge clk);
        end
        @(posedge clk);
        sb.note_sample(v);
        stall_count = 0;
    endtask

    // Drop push after the last sample of a stretch
    task automatic stop_sending();
        push <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every bin is out, then let a transform in flight finish
    task automatic drain();
        while (sb.pending() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(logic [2:0] code);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 1'b0;
        pwdata <= {29'($urandom()), code};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_length(code);
        stall_count = 0;
        @(posedge clk);
    endtask

    function logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    initial
    begin
        logic [2:0] lengths [12];
        int npts;
        int count;
        lengths = '{3'd3, 3'd1, 3'd2, 3'd7, 3'd4, 3'd0,
                    3'd2, 3'd6, 3'd5, 3'd3, 3'd1, 3'd2};
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: two-point blocks at the extremes of the sample range
        write_length(3'd1);
        send_sample(16'h7FFF); send_sample(16'h7FFF);
        send_sample(16'h8000); send_sample(16'h8000);
        send_sample(16'h7FFF); send_sample(16'h8000);
        send_sample(16'h8000); send_sample(16'h7FFF);
        stop_sending();
        drain();
        // Zero length code behaves as two points
        write_length(3'd0);
        send_sample(16'h0000); send_sample(16'hFFFF);
        stop_sending();
        drain();
        // A length write part-way through a block restarts loading
        write_length(3'd2);
        send_sample(16'h7FFF); send_sample(16'h8000); send_sample(16'h1234);
        stop_sending();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_length(3'd2);
        send_sample(16'h0001); send_sample(16'h8000);
        send_sample(16'h7FFF); send_sample(16'hFFFF);
        stop_sending();
        drain();

        // Random phases over several lengths; hold the output back in one
        for (int p = 0; p < 12; p++)
        begin
            write_length(lengths[p]);
            npts = 1 << ((lengths[p] == 0) ? 1 : (lengths[p] == 7) ? 6 : lengths[p]);
            quiet = (p == 4);
            if (npts >= 32)
                count = npts;
            else
                count = npts * $urandom_range(24 / npts + 1, 30 / npts + 1);
            if ($urandom_range(0, 2) == 0 && npts < 32)
                count += $urandom_range(1, npts - 1);
            if (p == 2)
            begin
                hold_request = 1'b1;
                count = 48;
            end
            for (int i = 0; i < count; i++)
                send_sample(pick_sample());
            stop_sending();
            // pause the sender until every bin has come out
            drain();
        end
        quiet = 1'b0;

        drain();
        repeat (300) @(posedge clk);
        leftover_errors = sb.pending();
        if (sb.mismatches == 0 && leftover_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
